### rtl/drs_pkg.sv
// Shared constants, types and helpers for the decimal radix sorter.
`default_nettype none

package drs_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int IDX_W       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W       = 31;
  localparam int TDATA_W     = 32;
  localparam int DIG_W       = 4;
  localparam int NUM_DIGITS  = 10;
  localparam int RCP_W       = 32;
  localparam int PROD_W      = VAL_W + RCP_W;
  localparam int ENT_W       = 2 * VAL_W;
  localparam int RECIP_SHIFT = 35;

  // ceil(2^35 / 10): exact quotient by ten for every 32-bit operand.
  localparam logic [RCP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic load_wr;
    logic clr_set;
    logic clr_counts;
    logic walk_start;
    logic scatter;
    logic prefix_step;
    logic pass_end;
    logic emit_init;
    logic emit_ld;
  } drs_cmd_t;

  typedef struct packed {
    logic walk_busy;
    logic prefix_last;
    logic largest_zero;
    logic emit_last;
    logic out_free;
  } drs_sts_t;

  // Takes the product of an operand and RECIP_TEN and returns operand / 10.
  function automatic val_t quot_ten(input logic [PROD_W-1:0] prod);
    return val_t'(prod[PROD_W-1:RECIP_SHIFT]);
  endfunction

endpackage

`default_nettype wire

### rtl/decimal_radix_sort.sv
// Top level of the decimal LSD radix sorter.
//
//  channel  | ports                  | beat contents
//  ---------+------------------------+--------------------------------------------
//  input    | in_tvalid/in_tready    | in_tdata: value; in_tlast: last of the set
//  result   | out_tvalid/out_tready  | out_tdata: sorted value; out_tlast: last;
//           |                        | out_tuser: items were dropped
//
// Loading takes one cycle per beat while in_tready is high; beats beyond 64 in a set
// are dropped and flagged. Each pass runs a count walk over the n stored items, a
// ten-step running sum and a scatter walk through the single read port of each bank;
// the number of passes equals the decimal digits of the largest value, up to ten.
// Results leave one at a time while out_tready is high; the last result
// may wait in the output register while the next set loads.
// Reset is synchronous and active low; no memory clearing pass is needed.
`default_nettype none

module decimal_radix_sort (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [drs_pkg::TDATA_W-1:0] in_tdata,   // [30:0] value, [31] zero
  input  wire logic                        in_tlast,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [drs_pkg::TDATA_W-1:0]      out_tdata,  // [30:0] sorted_value, [31] zero
  output logic                             out_tlast,
  output logic                             out_tuser   // [0] dropped
);
  import drs_pkg::*;

  drs_cmd_t cmd;
  drs_sts_t sts;
  val_t     out_value;

  drs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  drs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_tdata[VAL_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_value (out_value),
    .out_last  (out_tlast),
    .out_drop  (out_tuser)
  );

  assign out_tdata = {{(TDATA_W - VAL_W){1'b0}}, out_value};

endmodule

`default_nettype wire

### rtl/drs_dpath.sv
// Datapath of the decimal radix sorter: two banks, digit counters and output register.
`default_nettype none

module drs_dpath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [drs_pkg::VAL_W-1:0] in_value,
  input  wire drs_pkg::drs_cmd_t        cmd,
  output drs_pkg::drs_sts_t             sts,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [drs_pkg::VAL_W-1:0]     out_value,
  output logic                          out_last,
  output logic                          out_drop
);
  import drs_pkg::*;

  // Each entry holds the value and its quotient by the place value of the current pass.
  logic [ENT_W-1:0] mem0 [MAX_ITEMS];
  logic [ENT_W-1:0] mem1 [MAX_ITEMS];
  logic [ENT_W-1:0] q0_r, q1_r;

  logic             bank_r, bank_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             walk_r, walk_nxt;
  logic             scat_r, scat_nxt;
  logic             va_r, vb_r;
  val_t             valb_r, qb_r;
  logic [PROD_W-1:0] prodb_r;

  logic [CNT_W-1:0] counts_r [NUM_DIGITS];
  logic [CNT_W-1:0] counts_nxt [NUM_DIGITS];
  logic [DIG_W-1:0] pk_r, pk_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  val_t             lq_r, lq_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [ENT_W-1:0]  ent_a;
  val_t              val_a, q_a;
  val_t              q_next, ten_q, rem_b;
  logic [DIG_W-1:0]  dig_b;
  logic [DIG_W-1:0]  cnt_sel;
  logic [CNT_W-1:0]  cnt_rd, cnt_dec, cnt_upd;
  logic              cnt_we;
  logic [PROD_W-1:0] lq_prod;
  logic [IDX_W-1:0]  idx_top, ld_addr, sc_addr;
  logic [ENT_W-1:0]  ld_data, sc_data;
  logic              load_ok, sc_we;
  logic              we0, we1;
  logic [IDX_W-1:0]  wa0, wa1;
  logic [ENT_W-1:0]  wd0, wd1;
  logic              emit_last;

  // Read stage: entry from the bank that holds the current order.
  assign ent_a = bank_r ? q1_r : q0_r;
  assign val_a = ent_a[ENT_W-1:VAL_W];
  assign q_a   = ent_a[VAL_W-1:0];

  // Digit stage: q mod 10 = q - 10 * (q / 10).
  assign q_next = quot_ten(prodb_r);
  assign ten_q  = (q_next << 3) + (q_next << 1);
  assign rem_b  = qb_r - ten_q;
  assign dig_b  = rem_b[DIG_W-1:0];

  assign cnt_sel = cmd.prefix_step ? pk_r : dig_b;
  assign cnt_rd  = (cnt_sel < DIG_W'(NUM_DIGITS)) ? counts_r[cnt_sel] : '0;
  assign cnt_dec = cnt_rd - CNT_W'(1);

  assign idx_top   = IDX_W'(cnt_r - CNT_W'(1));
  assign emit_last = (CNT_W'(idx_r) == (cnt_r - CNT_W'(1)));
  assign lq_prod   = PROD_W'(lq_r) * PROD_W'(RECIP_TEN);

  // Loads go to the current bank, scatter writes to the other one.
  assign load_ok = cmd.load_wr && (cnt_r < CNT_W'(MAX_ITEMS));
  assign ld_addr = cnt_r[IDX_W-1:0];
  assign ld_data = {in_value, in_value};
  assign sc_we   = vb_r && scat_r;
  assign sc_addr = cnt_dec[IDX_W-1:0];
  assign sc_data = {valb_r, q_next};

  assign we0 = (load_ok && !bank_r) || (sc_we && bank_r);
  assign we1 = (load_ok && bank_r) || (sc_we && !bank_r);
  assign wa0 = bank_r ? sc_addr : ld_addr;
  assign wd0 = bank_r ? sc_data : ld_data;
  assign wa1 = bank_r ? ld_addr : sc_addr;
  assign wd1 = bank_r ? ld_data : sc_data;

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    q0_r <= mem0[idx_r];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    q1_r <= mem1[idx_r];
  end

  // Walk sequencing: ascending for counting, descending for the stable scatter.
  always_comb begin
    walk_nxt = walk_r;
    idx_nxt  = idx_r;
    scat_nxt = scat_r;
    if (cmd.walk_start) begin
      walk_nxt = 1'b1;
      scat_nxt = cmd.scatter;
      idx_nxt  = cmd.scatter ? idx_top : '0;
    end else if (walk_r) begin
      if (scat_r) begin
        if (idx_r == '0) begin
          walk_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end else begin
        if (idx_r == idx_top) begin
          walk_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
    end else if (cmd.emit_init) begin
      idx_nxt = '0;
    end else if (cmd.emit_ld) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  // Digit counters: histogram, running sum, then decrement per scattered entry.
  always_comb begin
    cnt_we  = 1'b0;
    cnt_upd = cnt_rd;
    acc_nxt = acc_r;
    pk_nxt  = pk_r;
    if (cmd.prefix_step) begin
      cnt_we  = 1'b1;
      cnt_upd = acc_r + cnt_rd;
      acc_nxt = acc_r + cnt_rd;
      pk_nxt  = pk_r + DIG_W'(1);
    end else if (vb_r) begin
      cnt_we  = 1'b1;
      cnt_upd = scat_r ? cnt_dec : (cnt_rd + CNT_W'(1));
    end
    for (int i = 0; i < NUM_DIGITS; i++) begin
      counts_nxt[i] = counts_r[i];
      if (cmd.clr_counts) begin
        counts_nxt[i] = '0;
      end else if (cnt_we && (cnt_sel == DIG_W'(i))) begin
        counts_nxt[i] = cnt_upd;
      end
    end
    if (cmd.clr_counts) begin
      acc_nxt = '0;
      pk_nxt  = '0;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    lq_nxt   = lq_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (cmd.clr_set) begin
      cnt_nxt = '0;
      lq_nxt  = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.load_wr) begin
      if (load_ok) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (in_value > lq_r) begin
          lq_nxt = in_value;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (cmd.pass_end) begin
      lq_nxt   = quot_ten(lq_prod);
      bank_nxt = !bank_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      idx_r       <= '0;
      walk_r      <= 1'b0;
      scat_r      <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      pk_r        <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      lq_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      bank_r      <= bank_nxt;
      idx_r       <= idx_nxt;
      walk_r      <= walk_nxt;
      scat_r      <= scat_nxt;
      va_r        <= walk_r;
      vb_r        <= va_r;
      pk_r        <= pk_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      lq_r        <= lq_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        counts_r[i] <= counts_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    valb_r  <= val_a;
    qb_r    <= q_a;
    prodb_r <= PROD_W'(q_a) * PROD_W'(RECIP_TEN);
    if (cmd.emit_ld) begin
      out_value <= val_a;
      out_last  <= emit_last;
      out_drop  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.walk_busy    = walk_r || va_r || vb_r;
  assign sts.prefix_last  = (pk_r == DIG_W'(NUM_DIGITS - 1));
  assign sts.largest_zero = (lq_r == '0);
  assign sts.emit_last    = emit_last;
  assign sts.out_free     = !out_valid_r || out_ready;

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (dig_b < DIG_W'(NUM_DIGITS)))
    else $error("digit out of range");

  a_scatter_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && scat_r) |-> (cnt_rd != '0))
    else $error("scatter into an exhausted digit bucket");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !scat_r) |-> (cnt_rd < cnt_r))
    else $error("digit histogram exceeds item count");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> !out_valid_r)
    else $error("output register overwritten while pending");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_wr |-> !(walk_r || va_r || vb_r))
    else $error("load during a walk");

endmodule

`default_nettype wire

### rtl/drs_ctrl.sv
// Controller state machine of the decimal radix sorter.
`default_nettype none

module drs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire drs_pkg::drs_sts_t sts,
  output drs_pkg::drs_cmd_t      cmd
);
  import drs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_COUNT   = 7'b0000100,
    S_PREFIX  = 7'b0001000,
    S_SCATTER = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_LD = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // A pass is needed while the largest value still has a digit left.
        if (sts.largest_zero) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else begin
          cmd.clr_counts = 1'b1;
          cmd.walk_start = 1'b1;
          state_nxt      = S_COUNT;
        end
      end
      S_COUNT: begin
        if (!sts.walk_busy) begin
          state_nxt = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cmd.prefix_step = 1'b1;
        if (sts.prefix_last) begin
          cmd.walk_start = 1'b1;
          cmd.scatter    = 1'b1;
          state_nxt      = S_SCATTER;
        end
      end
      S_SCATTER: begin
        if (!sts.walk_busy) begin
          cmd.pass_end = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_EMIT_RD: begin
        if (sts.out_free) begin
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        if (sts.emit_last) begin
          cmd.clr_set = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
